// ===== hw/rtl/lcdns_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdns_pkg: shared types and constants for the character-LCD sequencer
// Request codes, job kinds, register map, reset values and power-up timing.
// ----------------------------------------------------------------------------
package lcdns_pkg;

    // Request codes carried on req_type.
    typedef enum logic [1:0] {
        REQ_INIT = 2'd0,
        REQ_CMD  = 2'd1,
        REQ_DATA = 2'd2,
        REQ_TEXT = 2'd3
    } req_type_t;

    // Classified work handed from the front end to the back end.
    typedef enum logic [2:0] {
        JOB_INIT       = 3'd0,
        JOB_CMD        = 3'd1,
        JOB_DATA       = 3'd2,
        JOB_TEXT_PLAIN = 3'd3,
        JOB_TEXT_LINE2 = 3'd4,
        JOB_TEXT_START = 3'd5
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [7:0]  value;
    } job_t;

    // Register indexes (byte address is four times the index).
    typedef enum logic [2:0] {
        REG_LINE_LENGTH   = 3'd0,
        REG_FIRST_LINE    = 3'd1,
        REG_SECOND_LINE   = 3'd2,
        REG_NIBBLE_GAP    = 3'd3,
        REG_BYTE_GAP      = 3'd4
    } reg_index_t;

    // Configuration seen by the back end.
    typedef struct packed {
        logic [7:0]  first_line_command;
        logic [7:0]  second_line_command;
        logic [15:0] nibble_gap_us;
        logic [15:0] byte_gap_us;
    } cfg_t;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [5:0]  LINE_LENGTH_RST  = 6'd16;
    localparam logic [7:0]  FIRST_LINE_RST   = 8'h80;
    localparam logic [7:0]  SECOND_LINE_RST  = 8'hC0;
    localparam logic [15:0] NIBBLE_GAP_RST   = 16'd100;
    localparam logic [15:0] BYTE_GAP_RST     = 16'd5000;

    localparam logic [5:0]  CHARS_MAX        = 6'd63;

    // Command bytes used by the sequences.
    localparam logic [7:0]  CMD_CLEAR        = 8'h01;
    localparam logic [7:0]  CMD_ENTRY_MODE   = 8'h06;
    localparam logic [7:0]  CMD_DISPLAY_ON   = 8'h0F;

    // Power-up timing in microseconds.
    localparam logic [18:0] WAIT_POWER_UP    = 19'd500000;
    localparam logic [15:0] WAIT_WAKE_LONG   = 16'd50000;
    localparam logic [15:0] WAIT_WAKE_SHORT  = 16'd10000;
    localparam logic [3:0]  NIB_WAKE         = 4'h3;
    localparam logic [3:0]  NIB_FOUR_BIT     = 4'h2;
    localparam logic [3:0]  INIT_WAKE_STEPS  = 4'd4;

    // Index of the final pulse of each job.
    function automatic logic [3:0] last_step(input job_kind_t kind);
        logic [3:0] r;
        begin
            unique case (kind)
                JOB_INIT:       r = 4'd9;
                JOB_TEXT_LINE2: r = 4'd3;
                JOB_TEXT_START: r = 4'd5;
                default:        r = 4'd1;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== hw/rtl/lcdns_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdns_front: request classifier
// Turns each accepted request into a job and tracks characters on the line.
// ----------------------------------------------------------------------------
module lcdns_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         req_type,
    input  logic [7:0]         byte_value,
    input  logic               text_start,
    input  logic [5:0]         line_length,
    input  logic               q_full,
    output logic               q_push,
    output lcdns_pkg::job_t    q_job
);

    logic [5:0] chars_reg;
    logic [5:0] chars_next;
    logic [5:0] len;
    logic       accept;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign q_push = accept;
    assign len    = (line_length == 6'd0) ? 6'd1 : line_length;

    always_comb
    begin
        chars_next  = chars_reg;
        q_job.value = byte_value;
        q_job.kind  = lcdns_pkg::JOB_TEXT_PLAIN;
        unique case (lcdns_pkg::req_type_t'(req_type))
            lcdns_pkg::REQ_INIT: q_job.kind = lcdns_pkg::JOB_INIT;
            lcdns_pkg::REQ_CMD:  q_job.kind = lcdns_pkg::JOB_CMD;
            lcdns_pkg::REQ_DATA: q_job.kind = lcdns_pkg::JOB_DATA;
            default:
            begin
                if (text_start) begin
                    q_job.kind = lcdns_pkg::JOB_TEXT_START;
                    chars_next = 6'd1;
                end else begin
                    if (chars_reg == len && len != lcdns_pkg::CHARS_MAX) begin
                        q_job.kind = lcdns_pkg::JOB_TEXT_LINE2;
                    end
                    if (chars_reg != lcdns_pkg::CHARS_MAX) begin
                        chars_next = chars_reg + 6'd1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            chars_reg <= 6'd0;
        end else if (accept) begin
            chars_reg <= chars_next;
        end
    end

endmodule

// ===== hw/rtl/lcdns_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdns_queue: job queue
// Short first-in first-out buffer between the classifier and the sequencer.
// ----------------------------------------------------------------------------
module lcdns_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lcdns_pkg::job_t    push_job,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output lcdns_pkg::job_t    head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    lcdns_pkg::job_t  mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== hw/rtl/lcdns_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdns_back: pulse sequencer
// Steps through the pulses of the head job, one word a cycle when not stalled.
// ----------------------------------------------------------------------------
module lcdns_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  lcdns_pkg::cfg_t    cfg,
    input  logic               q_empty,
    input  lcdns_pkg::job_t    q_head,
    output logic               q_pop,
    output logic               empty,
    input  logic               pop,
    output logic [3:0]         nibble,
    output logic               register_select,
    output logic [18:0]        wait_before_us,
    output logic [15:0]        wait_after_us,
    output logic               last
);

    logic [3:0]  step_reg;
    logic [3:0]  step_next;
    logic        valid_reg;
    logic        valid_next;
    logic        advance;
    logic        final_step;
    logic [3:0]  pos;
    logic [2:0]  byte_sel;
    logic [7:0]  cur_byte;
    logic        cur_rs;

    logic [3:0]  nibble_next;
    logic        rs_next;
    logic [18:0] before_next;
    logic [15:0] after_next;

    logic [3:0]  nibble_reg;
    logic        rs_reg;
    logic [18:0] before_reg;
    logic [15:0] after_reg;
    logic        last_reg;

    assign advance    = !q_empty && (!valid_reg || pop);
    assign final_step = (step_reg == lcdns_pkg::last_step(q_head.kind));
    assign q_pop      = advance && final_step;
    assign pos        = (q_head.kind == lcdns_pkg::JOB_INIT)
                        ? step_reg - lcdns_pkg::INIT_WAKE_STEPS : step_reg;
    assign byte_sel   = pos[3:1];

    always_comb
    begin
        cur_byte = q_head.value;
        cur_rs   = 1'b1;
        unique case (q_head.kind)
            lcdns_pkg::JOB_INIT:
            begin
                cur_rs = 1'b0;
                unique case (byte_sel)
                    3'd0:    cur_byte = lcdns_pkg::CMD_CLEAR;
                    3'd1:    cur_byte = lcdns_pkg::CMD_ENTRY_MODE;
                    default: cur_byte = lcdns_pkg::CMD_DISPLAY_ON;
                endcase
            end
            lcdns_pkg::JOB_CMD:  cur_rs = 1'b0;
            lcdns_pkg::JOB_DATA: cur_rs = 1'b1;
            lcdns_pkg::JOB_TEXT_LINE2:
            begin
                if (byte_sel == 3'd0) begin
                    cur_byte = cfg.second_line_command;
                    cur_rs   = 1'b0;
                end
            end
            lcdns_pkg::JOB_TEXT_START:
            begin
                if (byte_sel == 3'd0) begin
                    cur_byte = lcdns_pkg::CMD_CLEAR;
                    cur_rs   = 1'b0;
                end else if (byte_sel == 3'd1) begin
                    cur_byte = cfg.first_line_command;
                    cur_rs   = 1'b0;
                end
            end
            default: cur_rs = 1'b1;
        endcase
    end

    always_comb
    begin
        nibble_next = pos[0] ? cur_byte[3:0] : cur_byte[7:4];
        rs_next     = cur_rs;
        before_next = '0;
        after_next  = pos[0] ? cfg.byte_gap_us : cfg.nibble_gap_us;
        // Power-up wake-up pulses precede the normal byte transfers.
        if (q_head.kind == lcdns_pkg::JOB_INIT && step_reg < lcdns_pkg::INIT_WAKE_STEPS) begin
            rs_next     = 1'b0;
            nibble_next = (step_reg == 4'd3) ? lcdns_pkg::NIB_FOUR_BIT : lcdns_pkg::NIB_WAKE;
            before_next = (step_reg == 4'd0) ? lcdns_pkg::WAIT_POWER_UP : '0;
            after_next  = (step_reg < 4'd2) ? lcdns_pkg::WAIT_WAKE_LONG
                                            : lcdns_pkg::WAIT_WAKE_SHORT;
        end
    end

    always_comb
    begin
        step_next  = step_reg;
        valid_next = valid_reg;
        if (advance) begin
            valid_next = 1'b1;
            step_next  = final_step ? 4'd0 : step_reg + 4'd1;
        end else if (pop) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            step_reg  <= 4'd0;
            valid_reg <= 1'b0;
        end else begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            nibble_reg <= nibble_next;
            rs_reg     <= rs_next;
            before_reg <= before_next;
            after_reg  <= after_next;
            last_reg   <= final_step;
        end
    end

    assign empty           = !valid_reg;
    assign nibble          = nibble_reg;
    assign register_select = rs_reg;
    assign wait_before_us  = before_reg;
    assign wait_after_us   = after_reg;
    assign last            = last_reg;

endmodule

// ===== hw/rtl/char_lcd_nibble_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer: 4-bit character-LCD transfer sequencer
// Turns init, command, data and text requests into enable-pulse words.
// ----------------------------------------------------------------------------
//
//  Channel   | Direction | Handshake            | Word contents
//  ----------+-----------+----------------------+-------------------------------
//  request   | in        | push / full          | req_type, byte_value, text_start
//  pulse     | out       | pop / empty          | nibble, register_select,
//            |           |                      | wait_before_us, wait_after_us, last
//  config    | in        | APB psel/penable     | five registers at 4*index
//
// One pulse word leaves per cycle while pop is held high. A request produces
// 2 to 10 words (init 10, text start 6, line change 4, otherwise 2), so the
// pulse sequencer, which emits one word a cycle, sets the sustained request
// rate. Requests are taken one per cycle until the job queue between the
// classifier and the sequencer is full. Reset clears the queue, the line
// counter and the output valid flag; no clearing pass is needed. A stalled
// output holds its word while new requests keep arriving.
//
// The front end classifies each request as it is accepted, so the character
// counter always reflects request order, independent of back-end stalls. The
// back end reads the address and gap registers live, safe only if the user
// sees that configuration is only changed while the block is idle (unenforced).
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // Request side
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    req_type,
    input  logic [7:0]                    byte_value,
    input  logic                          text_start,
    // Pulse side
    output logic                          empty,
    input  logic                          pop,
    output logic [3:0]                    nibble,
    output logic                          register_select,
    output logic [18:0]                   wait_before_us,
    output logic [15:0]                   wait_after_us,
    output logic                          last,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lcdns_pkg::ADDR_W-1:0]  paddr,
    input  logic [lcdns_pkg::DATA_W-1:0]  pwdata,
    output logic [lcdns_pkg::DATA_W-1:0]  prdata,
    output logic                          pready
);

    logic [5:0]   line_length_reg;
    logic [7:0]   first_line_reg;
    logic [7:0]   second_line_reg;
    logic [15:0]  nibble_gap_reg;
    logic [15:0]  byte_gap_reg;

    logic         cfg_write;
    lcdns_pkg::reg_index_t reg_idx;
    lcdns_pkg::cfg_t       cfg;

    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    lcdns_pkg::job_t  q_in;
    lcdns_pkg::job_t  q_head;

    // ------------------------------------------------------------------
    // Configuration registers. The port never inserts wait states.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = lcdns_pkg::reg_index_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg <= lcdns_pkg::LINE_LENGTH_RST;
            first_line_reg  <= lcdns_pkg::FIRST_LINE_RST;
            second_line_reg <= lcdns_pkg::SECOND_LINE_RST;
            nibble_gap_reg  <= lcdns_pkg::NIBBLE_GAP_RST;
            byte_gap_reg    <= lcdns_pkg::BYTE_GAP_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                lcdns_pkg::REG_LINE_LENGTH: line_length_reg <= pwdata[5:0];
                lcdns_pkg::REG_FIRST_LINE:  first_line_reg  <= pwdata[7:0];
                lcdns_pkg::REG_SECOND_LINE: second_line_reg <= pwdata[7:0];
                lcdns_pkg::REG_NIBBLE_GAP:  nibble_gap_reg  <= pwdata[15:0];
                lcdns_pkg::REG_BYTE_GAP:    byte_gap_reg    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read-back; unmapped addresses read as zero.
    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            lcdns_pkg::REG_LINE_LENGTH: prdata = {26'd0, line_length_reg};
            lcdns_pkg::REG_FIRST_LINE:  prdata = {24'd0, first_line_reg};
            lcdns_pkg::REG_SECOND_LINE: prdata = {24'd0, second_line_reg};
            lcdns_pkg::REG_NIBBLE_GAP:  prdata = {16'd0, nibble_gap_reg};
            lcdns_pkg::REG_BYTE_GAP:    prdata = {16'd0, byte_gap_reg};
            default:                    prdata = '0;
        endcase
    end

    assign cfg.first_line_command  = first_line_reg;
    assign cfg.second_line_command = second_line_reg;
    assign cfg.nibble_gap_us       = nibble_gap_reg;
    assign cfg.byte_gap_us         = byte_gap_reg;

    // ------------------------------------------------------------------
    // Front end: classifies each request and keeps the line counter.
    // ------------------------------------------------------------------
    lcdns_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .req_type    (req_type),
        .byte_value  (byte_value),
        .text_start  (text_start),
        .line_length (line_length_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_job       (q_in)
    );

    // ------------------------------------------------------------------
    // Job queue decoupling the two halves.
    // ------------------------------------------------------------------
    lcdns_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    // ------------------------------------------------------------------
    // Back end: walks through the pulses of each job into the output
    // register, one word per cycle while not stalled.
    // ------------------------------------------------------------------
    lcdns_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .q_empty         (q_empty),
        .q_head          (q_head),
        .q_pop           (q_pop),
        .empty           (empty),
        .pop             (pop),
        .nibble          (nibble),
        .register_select (register_select),
        .wait_before_us  (wait_before_us),
        .wait_after_us   (wait_after_us),
        .last            (last)
    );

endmodule

// ===== dv/tb_char_lcd_nibble_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_sequencer: self-checking bench for the LCD sequencer
// Drives init, command, data and text requests through the push/full queue,
// predicts every enable-pulse word in order, and compares each popped word
// field by field. The registers are set over the APB port only while the
// block is idle, and read back after every write. A short directed table
// comes first, then random requests under three further register settings
// with random idling on both sides under the first two of them.
// ----------------------------------------------------------------------------
module tb_char_lcd_nibble_sequencer;

    // Generous cycle limit for some 100 requests of at most ten words each,
    // with a receiver that stalls up to about half the time.
    localparam int LIMIT_CYCLES = 200000;
    localparam int REPORT_MAX   = 10;

    // One enable pulse as seen on the result ports.
    typedef struct packed {
        logic [3:0]  nib;
        logic        rs;
        logic [18:0] pre_us;
        logic [15:0] post_us;
        logic        is_last;
    } pulse_word_t;

    // One row of the directed table. Where typed is set, the first pulse word
    // of the request is taken from the row rather than from the predictor.
    typedef struct packed {
        lcdns_pkg::req_type_t req;
        logic [7:0]           val;
        logic                 start;
        logic                 typed;
        pulse_word_t          first;
    } stim_row_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           push = 1'b0;
    logic                           full;
    logic [1:0]                     req_type = '0;
    logic [7:0]                     byte_value = '0;
    logic                           text_start = 1'b0;
    logic                           empty;
    logic                           pop = 1'b0;
    logic [3:0]                     nibble;
    logic                           register_select;
    logic [18:0]                    wait_before_us;
    logic [15:0]                    wait_after_us;
    logic                           last;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [lcdns_pkg::ADDR_W-1:0]   paddr = '0;
    logic [lcdns_pkg::DATA_W-1:0]   pwdata = '0;
    logic [lcdns_pkg::DATA_W-1:0]   prdata;
    logic                           pready;

    // Our own copy of the register file and the line counter.
    logic [5:0]           cfg_line_length;
    logic [7:0]           cfg_first_cmd;
    logic [7:0]           cfg_second_cmd;
    logic [15:0]          cfg_nibble_gap;
    logic [15:0]          cfg_byte_gap;
    logic [5:0]           chars_on_line;

    // Words predicted for the request being accepted, and every word still
    // owed by the block, oldest first.
    pulse_word_t          pulse_burst[$];
    pulse_word_t          pulses_due[$];

    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;
    int                   fail_count = 0;
    int                   requests_taken = 0;
    int                   words_checked = 0;
    int                   line_changes = 0;
    int                   settings_run = 0;
    int                   cycle_count = 0;

    // Directed table, run with line_length written to zero (so a line holds
    // a single character) and the remaining registers at their reset values.
    stim_row_t directed_rows [16] = '{
        // Power-up sequence straight after reset.
        '{lcdns_pkg::REQ_INIT, 8'h00, 1'b0, 1'b1, '{4'h3, 1'b0, 19'd500000, 16'd50000, 1'b0}},
        // Command and data bytes at both extremes.
        '{lcdns_pkg::REQ_CMD,  8'h00, 1'b0, 1'b1, '{4'h0, 1'b0, 19'd0, 16'd100, 1'b0}},
        '{lcdns_pkg::REQ_CMD,  8'hFF, 1'b0, 1'b1, '{4'hF, 1'b0, 19'd0, 16'd100, 1'b0}},
        '{lcdns_pkg::REQ_DATA, 8'h00, 1'b0, 1'b1, '{4'h0, 1'b1, 19'd0, 16'd100, 1'b0}},
        '{lcdns_pkg::REQ_DATA, 8'hFF, 1'b0, 1'b1, '{4'hF, 1'b1, 19'd0, 16'd100, 1'b0}},
        // Text without a string start after reset, then a line change, then
        // a character beyond the second line.
        '{lcdns_pkg::REQ_TEXT, 8'h41, 1'b0, 1'b0, '0},
        '{lcdns_pkg::REQ_TEXT, 8'h42, 1'b0, 1'b0, '0},
        '{lcdns_pkg::REQ_TEXT, 8'h43, 1'b0, 1'b0, '0},
        // A string start opens with the high nibble of the clear command.
        '{lcdns_pkg::REQ_TEXT, 8'h44, 1'b1, 1'b1, '{4'h0, 1'b0, 19'd0, 16'd100, 1'b0}},
        '{lcdns_pkg::REQ_TEXT, 8'h45, 1'b0, 1'b0, '0},
        // The start flag must be ignored on every request but text.
        '{lcdns_pkg::REQ_INIT, 8'hFF, 1'b1, 1'b1, '{4'h3, 1'b0, 19'd500000, 16'd50000, 1'b0}},
        '{lcdns_pkg::REQ_CMD,  8'h5A, 1'b1, 1'b0, '0},
        '{lcdns_pkg::REQ_DATA, 8'hA5, 1'b1, 1'b0, '0},
        '{lcdns_pkg::REQ_TEXT, 8'h00, 1'b1, 1'b1, '{4'h0, 1'b0, 19'd0, 16'd100, 1'b0}},
        '{lcdns_pkg::REQ_TEXT, 8'hFF, 1'b0, 1'b0, '0},
        '{lcdns_pkg::REQ_TEXT, 8'h80, 1'b0, 1'b0, '0}
    };

    char_lcd_nibble_sequencer uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .req_type        (req_type),
        .byte_value      (byte_value),
        .text_start      (text_start),
        .empty           (empty),
        .pop             (pop),
        .nibble          (nibble),
        .register_select (register_select),
        .wait_before_us  (wait_before_us),
        .wait_after_us   (wait_after_us),
        .last            (last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // 12 ns clock.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Timed out after %0d cycles with %0d words still owed.",
                     cycle_count, pulses_due.size());
            $display("FAIL char_lcd_nibble_sequencer");
            $finish;
        end
    end

    // Every failure goes through here; only the first few are spelt out.
    task automatic note_failure(input string what, input logic [31:0] want,
                                input logic [31:0] got);
        begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
                $display("[%0t] %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
        end
    endtask

    // ------------------------------------------------------------------------
    // Predictor. Each accepted request is expanded into its pulse words.
    // ------------------------------------------------------------------------
    function automatic void add_pulse(input logic [3:0] nib, input logic rs,
                                      input logic [18:0] pre_us,
                                      input logic [15:0] post_us, input logic is_last);
        pulse_word_t w;
        begin
            w.nib     = nib;
            w.rs      = rs;
            w.pre_us  = pre_us;
            w.post_us = post_us;
            w.is_last = is_last;
            pulse_burst.push_back(w);
        end
    endfunction

    // A whole byte is two pulses: high nibble with the nibble gap after it,
    // then low nibble with the byte gap.
    function automatic void add_byte(input logic [7:0] b, input logic rs,
                                     input logic is_last);
        begin
            add_pulse(b[7:4], rs, 19'd0, cfg_nibble_gap, 1'b0);
            add_pulse(b[3:0], rs, 19'd0, cfg_byte_gap, is_last);
        end
    endfunction

    function automatic void predict_pulses(input lcdns_pkg::req_type_t req,
                                           input logic [7:0] val, input logic start);
        logic [5:0] line_len;
        begin
            pulse_burst.delete();
            case (req)
                lcdns_pkg::REQ_INIT:
                begin
                    // Wake-up nibbles, only the very first waits for power-up.
                    add_pulse(lcdns_pkg::NIB_WAKE, 1'b0, lcdns_pkg::WAIT_POWER_UP,
                              lcdns_pkg::WAIT_WAKE_LONG, 1'b0);
                    add_pulse(lcdns_pkg::NIB_WAKE, 1'b0, 19'd0,
                              lcdns_pkg::WAIT_WAKE_LONG, 1'b0);
                    add_pulse(lcdns_pkg::NIB_WAKE, 1'b0, 19'd0,
                              lcdns_pkg::WAIT_WAKE_SHORT, 1'b0);
                    add_pulse(lcdns_pkg::NIB_FOUR_BIT, 1'b0, 19'd0,
                              lcdns_pkg::WAIT_WAKE_SHORT, 1'b0);
                    add_byte(lcdns_pkg::CMD_CLEAR, 1'b0, 1'b0);
                    add_byte(lcdns_pkg::CMD_ENTRY_MODE, 1'b0, 1'b0);
                    add_byte(lcdns_pkg::CMD_DISPLAY_ON, 1'b0, 1'b1);
                end
                lcdns_pkg::REQ_CMD:  add_byte(val, 1'b0, 1'b1);
                lcdns_pkg::REQ_DATA: add_byte(val, 1'b1, 1'b1);
                default:
                begin
                    // A zero line length behaves as one character per line.
                    line_len = (cfg_line_length == 6'd0) ? 6'd1 : cfg_line_length;
                    if (start)
                    begin
                        add_byte(lcdns_pkg::CMD_CLEAR, 1'b0, 1'b0);
                        add_byte(cfg_first_cmd, 1'b0, 1'b0);
                        chars_on_line = 6'd0;
                    end
                    else if (chars_on_line == line_len && line_len < lcdns_pkg::CHARS_MAX)
                    begin
                        add_byte(cfg_second_cmd, 1'b0, 1'b0);
                        line_changes++;
                    end
                    add_byte(val, 1'b1, 1'b1);
                    if (chars_on_line < lcdns_pkg::CHARS_MAX)
                        chars_on_line = chars_on_line + 6'd1;
                end
            endcase
        end
    endfunction

    // ------------------------------------------------------------------------
    // Request side. The task is entered just after a rising edge; push is
    // left high after acceptance so that back-to-back requests never lower
    // and raise it in the same time step.
    // ------------------------------------------------------------------------
    task automatic send_request(input lcdns_pkg::req_type_t req, input logic [7:0] val,
                                input logic start, input logic typed,
                                input pulse_word_t typed_first);
        int k;
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                push <= 1'b0;
                @(posedge clk);
            end
            push       <= 1'b1;
            req_type   <= req;
            byte_value <= val;
            text_start <= start;
            @(posedge clk);
            while (full)
                @(posedge clk);
            // Accepted at this edge: work out and queue its words.
            requests_taken++;
            predict_pulses(req, val, start);
            for (k = 0; k < pulse_burst.size(); k++)
                pulses_due.push_back((k == 0 && typed) ? typed_first : pulse_burst[k]);
        end
    endtask

    task automatic random_requests(input int count, input int text_pct,
                                   input int start_pct);
        int                    i;
        lcdns_pkg::req_type_t  req;
        logic [7:0]            val;
        logic                  start;
        begin
            for (i = 0; i < count; i++)
            begin
                val = 8'($urandom);
                if ($urandom_range(99) < text_pct)
                begin
                    req   = lcdns_pkg::REQ_TEXT;
                    start = ($urandom_range(99) < start_pct);
                end
                else
                begin
                    req   = lcdns_pkg::req_type_t'($urandom_range(2));
                    start = 1'($urandom);
                end
                send_request(req, val, start, 1'b0, '0);
            end
        end
    endtask

    // Stop sending and let the block run dry. Every request yields at least
    // two words, so once none is owed the block holds no work; an extra wait
    // then covers the output register.
    task automatic drain_pulses;
        begin
            push <= 1'b0;
            @(posedge clk);
            while (pulses_due.size() != 0)
                @(posedge clk);
            repeat (4) @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side. The oldest word is compared whenever it is popped; pop is
    // redrawn at every edge to give random stalls.
    // ------------------------------------------------------------------------
    task automatic check_pulse_word;
        pulse_word_t want;
        begin
            words_checked++;
            if (pulses_due.size() == 0)
                note_failure("unexpected pulse word, nibble", 32'd0, 32'(nibble));
            else
            begin
                want = pulses_due.pop_front();
                if (nibble !== want.nib)
                    note_failure("nibble", 32'(want.nib), 32'(nibble));
                if (register_select !== want.rs)
                    note_failure("register_select", 32'(want.rs), 32'(register_select));
                if (wait_before_us !== want.pre_us)
                    note_failure("wait_before_us", 32'(want.pre_us), 32'(wait_before_us));
                if (wait_after_us !== want.post_us)
                    note_failure("wait_after_us", 32'(want.post_us), 32'(wait_after_us));
                if (last !== want.is_last)
                    note_failure("last", 32'(want.is_last), 32'(last));
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            check_pulse_word();
        pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Configuration port. A transfer goes setup then access; psel is kept
    // high between transfers and only dropped by bus_release.
    // ------------------------------------------------------------------------
    task automatic read_register(input lcdns_pkg::reg_index_t idx, input logic [31:0] want);
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= {idx, 2'b00};
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready)
                @(posedge clk);
            if (prdata !== want)
                note_failure($sformatf("register %s read back", idx.name()), want, prdata);
        end
    endtask

    task automatic program_register(input lcdns_pkg::reg_index_t idx,
                                    input logic [31:0] val);
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {idx, 2'b00};
            pwdata  <= val;
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready)
                @(posedge clk);
            case (idx)
                lcdns_pkg::REG_LINE_LENGTH: cfg_line_length = val[5:0];
                lcdns_pkg::REG_FIRST_LINE:  cfg_first_cmd   = val[7:0];
                lcdns_pkg::REG_SECOND_LINE: cfg_second_cmd  = val[7:0];
                lcdns_pkg::REG_NIBBLE_GAP:  cfg_nibble_gap  = val[15:0];
                default:                    cfg_byte_gap    = val[15:0];
            endcase
            read_register(idx, val);
        end
    endtask

    task automatic bus_release;
        begin
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic program_all(input logic [5:0] line_len, input logic [7:0] first_cmd,
                               input logic [7:0] second_cmd, input logic [15:0] nib_gap,
                               input logic [15:0] byte_gap);
        begin
            program_register(lcdns_pkg::REG_LINE_LENGTH, 32'(line_len));
            program_register(lcdns_pkg::REG_FIRST_LINE, 32'(first_cmd));
            program_register(lcdns_pkg::REG_SECOND_LINE, 32'(second_cmd));
            program_register(lcdns_pkg::REG_NIBBLE_GAP, 32'(nib_gap));
            program_register(lcdns_pkg::REG_BYTE_GAP, 32'(byte_gap));
            bus_release();
            settings_run++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        cfg_line_length = lcdns_pkg::LINE_LENGTH_RST;
        cfg_first_cmd   = lcdns_pkg::FIRST_LINE_RST;
        cfg_second_cmd  = lcdns_pkg::SECOND_LINE_RST;
        cfg_nibble_gap  = lcdns_pkg::NIBBLE_GAP_RST;
        cfg_byte_gap    = lcdns_pkg::BYTE_GAP_RST;
        chars_on_line   = 6'd0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values first, then a line length of zero for the table.
        read_register(lcdns_pkg::REG_LINE_LENGTH, 32'(lcdns_pkg::LINE_LENGTH_RST));
        read_register(lcdns_pkg::REG_FIRST_LINE, 32'(lcdns_pkg::FIRST_LINE_RST));
        read_register(lcdns_pkg::REG_SECOND_LINE, 32'(lcdns_pkg::SECOND_LINE_RST));
        read_register(lcdns_pkg::REG_NIBBLE_GAP, 32'(lcdns_pkg::NIBBLE_GAP_RST));
        read_register(lcdns_pkg::REG_BYTE_GAP, 32'(lcdns_pkg::BYTE_GAP_RST));
        program_register(lcdns_pkg::REG_LINE_LENGTH, 32'd0);
        bus_release();
        settings_run++;

        // Sender idles rarely, receiver about half the time.
        send_idle_pct = 14;
        recv_idle_pct = 52;
        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].val, directed_rows[i].start,
                         directed_rows[i].typed, directed_rows[i].first);
        drain_pulses();

        // Shortest line, extreme address commands, zero and full-scale gaps.
        // Frequent string starts keep the line change busy.
        program_all(6'd1, 8'hFF, 8'h80, 16'd0, 16'hFFFF);
        random_requests(8, 55, 20);
        drain_pulses();

        // Roles swapped: the receiver is now the eager side.
        send_idle_pct = 52;
        recv_idle_pct = 14;

        // A line length of 63 can never be reached before the counter
        // saturates, so one long string must run without any line change.
        program_all(6'd63, 8'h80, 8'hFF, 16'hFFFF, 16'd0);
        send_request(lcdns_pkg::REQ_TEXT, 8'($urandom), 1'b1, 1'b0, '0);
        random_requests(72, 94, 0);
        drain_pulses();

        // No idling at all; a line of 40 characters, random addresses and gaps,
        // long strings with an occasional restart.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        program_all(6'd40, 8'($urandom_range(128, 255)), 8'($urandom_range(128, 255)),
                    16'($urandom), 16'($urandom));
        send_request(lcdns_pkg::REQ_TEXT, 8'($urandom), 1'b1, 1'b0, '0);
        random_requests(8, 85, 3);
        drain_pulses();

        // Anything still arriving now is a word nobody asked for.
        repeat (16) @(posedge clk);

        $display("Ran %0d requests under %0d register settings; %0d pulse words checked.",
                 requests_taken, settings_run, words_checked);
        $display("Line changes predicted: %0d; failures: %0d.", line_changes, fail_count);
        if (fail_count == 0)
            $display("PASS char_lcd_nibble_sequencer");
        else
            $display("FAIL char_lcd_nibble_sequencer");
        $finish;
    end

endmodule
